/* design/bounded_list_table_engine_assert.svh */
// Assertion macros for the bounded list table engine checker.
// Needs nothing else; included by the checker file.
`ifndef BOUNDED_LIST_TABLE_ENGINE_ASSERT_SVH
`define BOUNDED_LIST_TABLE_ENGINE_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define BLTE_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("bounded list table engine: assertion failed");

// Clocked assertion that also holds during reset.
`define BLTE_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("bounded list table engine: assertion failed");

`endif

/* design/bl_pkg.sv */
// Package for the bounded list table engine: sizes, codes and the structs
// passed between the controller and the cell chain. No dependencies.
`timescale 1ns / 1ps

package bl_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int LEN_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int CMD_W   = 3;
    localparam int POS_W   = 4;
    localparam int STAT_W  = 3;
    localparam int OIDX_W  = 4;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT  = 3'd0,
        CMD_PUSH_BACK   = 3'd1,
        CMD_SEARCH      = 3'd2,
        CMD_READ        = 3'd3,
        CMD_FIND_INSERT = 3'd4,
        CMD_REMOVE_MID  = 3'd5
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_RANGE     = 3'd3,
        ST_FULL      = 3'd4,
        ST_EVEN      = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_SHIFT_UP,
        OP_SHIFT_DOWN,
        OP_WRITE
    } op_kind_t;

    // Update applied to every cell in the same cycle.
    typedef struct packed {
        op_kind_t           kind;
        logic [LEN_W-1:0]   pivot;
        logic [DATA_W-1:0]  wdata;
    } cell_op_t;

    // Lookup token that walks the chain one cell per cycle.
    typedef struct packed {
        logic               valid;
        logic [DATA_W-1:0]  key;
        logic [LEN_W-1:0]   tgt;
        logic               found;
        logic [IDX_W-1:0]   fidx;
        logic [DATA_W-1:0]  rval;
    } tok_t;

endpackage

/* design/bl_cell.sv */
// One list cell: holds one entry and one stage of the lookup token.
// Depends on bl_pkg.
`timescale 1ns / 1ps

module bl_cell
    import bl_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [LEN_W-1:0]  cell_index,
    input  logic [LEN_W-1:0]  length,
    input  cell_op_t          op,
    input  logic [DATA_W-1:0] lower_entry,
    input  logic [DATA_W-1:0] upper_entry,
    input  tok_t              tok_in,
    output logic [DATA_W-1:0] entry,
    output tok_t              tok_out
);

    logic [DATA_W-1:0] entry_reg, entry_next;
    tok_t              tok_reg, tok_next;

    always_comb begin
        entry_next = entry_reg;
        case (op.kind)
            OP_SHIFT_UP: entry_next = lower_entry;
            OP_SHIFT_DOWN: begin
                if (cell_index >= op.pivot) begin
                    entry_next = upper_entry;
                end
            end
            OP_WRITE: begin
                if (cell_index == op.pivot) begin
                    entry_next = op.wdata;
                end
            end
            default: entry_next = entry_reg;
        endcase
    end

    always_comb begin
        tok_next = tok_in;
        // first live match wins; later cells see found already set
        if (cell_index < length && !tok_in.found && entry_reg == tok_in.key) begin
            tok_next.found = 1'b1;
            tok_next.fidx  = cell_index[IDX_W-1:0];
        end
        if (cell_index == tok_in.tgt) begin
            tok_next.rval = entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign entry   = entry_reg;
    assign tok_out = tok_reg;

endmodule

/* design/bl_ctrl.sv */
// Command controller: takes requests, launches the lookup token, decides the
// result and the list update, and holds the output register. Uses bl_pkg.
`timescale 1ns / 1ps

module bl_ctrl
    import bl_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    output tok_t             tok_launch,
    input  tok_t             tok_exit,
    output cell_op_t         cell_op,
    output logic [LEN_W-1:0] length
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINISH
    } state_t;

    state_t             state_reg, state_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [DATA_W-1:0]  value_reg, value_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [LEN_W-1:0]   length_reg, length_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   fidx_reg, fidx_next;
    logic [DATA_W-1:0]  rval_reg, rval_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]   m_tdata_reg, m_tdata_next;

    logic               accept;
    logic               commit;
    logic [CMD_W-1:0]   s_command;
    logic [DATA_W-1:0]  s_value;
    logic [POS_W-1:0]   s_position;
    logic               is_full;
    logic [LEN_W-1:0]   mid;
    logic [LEN_W-1:0]   pos_ext;

    status_t            res_status;
    logic [DATA_W-1:0]  res_value;
    logic [OIDX_W-1:0]  res_index;
    logic               res_inserted;
    logic [LEN_W-1:0]   res_length;
    cell_op_t           res_op;

    assign s_command  = s_tdata[CMD_W-1:0];
    assign s_value    = s_tdata[CMD_W+DATA_W-1:CMD_W];
    assign s_position = s_tdata[CMD_W+DATA_W+POS_W-1:CMD_W+DATA_W];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign commit   = (state_reg == S_FINISH) && (!m_tvalid_reg || m_tready);
    assign is_full  = (length_reg >= LEN_W'(DEPTH));
    assign mid      = length_reg >> 1;
    assign pos_ext  = LEN_W'(pos_reg);

    // launch the token straight from the request into cell 0
    always_comb begin
        tok_launch       = '0;
        tok_launch.valid = accept;
        tok_launch.key   = s_value;
        case (s_command)
            CMD_READ:       tok_launch.tgt = LEN_W'(s_position);
            CMD_REMOVE_MID: tok_launch.tgt = mid;
            default:        tok_launch.tgt = LEN_W'(DEPTH);
        endcase
    end

    always_comb begin
        res_status   = ST_OK;
        res_value    = '0;
        res_index    = '0;
        res_inserted = 1'b0;
        res_length   = length_reg;
        res_op.kind  = OP_HOLD;
        res_op.pivot = length_reg;
        res_op.wdata = value_reg;
        unique case (cmd_reg)
            CMD_PUSH_FRONT: begin
                if (is_full) begin
                    res_status = ST_FULL;
                end else begin
                    res_op.kind = OP_SHIFT_UP;
                    res_length  = length_reg + 1'b1;
                end
            end
            CMD_PUSH_BACK: begin
                if (is_full) begin
                    res_status = ST_FULL;
                end else begin
                    res_op.kind = OP_WRITE;
                    res_index   = OIDX_W'(length_reg);
                    res_length  = length_reg + 1'b1;
                end
            end
            CMD_SEARCH: begin
                if (found_reg) begin
                    res_index = OIDX_W'(fidx_reg);
                end else begin
                    res_status = ST_NOT_FOUND;
                end
            end
            CMD_READ: begin
                if (length_reg == '0) begin
                    res_status = ST_EMPTY;
                end else if (pos_ext >= length_reg) begin
                    res_status = ST_RANGE;
                end else begin
                    res_value = rval_reg;
                    res_index = pos_reg;
                end
            end
            CMD_FIND_INSERT: begin
                if (found_reg) begin
                    res_index = OIDX_W'(fidx_reg);
                end else if (is_full) begin
                    res_status = ST_FULL;
                end else begin
                    res_op.kind  = OP_WRITE;
                    res_index    = OIDX_W'(length_reg);
                    res_inserted = 1'b1;
                    res_length   = length_reg + 1'b1;
                end
            end
            CMD_REMOVE_MID: begin
                if (length_reg == '0) begin
                    res_status = ST_EMPTY;
                end else if (!length_reg[0]) begin
                    res_status = ST_EVEN;
                end else begin
                    res_op.kind  = OP_SHIFT_DOWN;
                    res_op.pivot = mid;
                    res_value    = rval_reg;
                    res_index    = OIDX_W'(mid);
                    res_length   = length_reg - 1'b1;
                end
            end
            default: res_status = ST_RANGE;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        value_next    = value_reg;
        pos_next      = pos_reg;
        length_next   = length_reg;
        found_next    = found_reg;
        fidx_next     = fidx_reg;
        rval_next     = rval_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        cell_op       = res_op;
        cell_op.kind  = OP_HOLD;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd_next   = s_command;
                    value_next = s_value;
                    pos_next   = s_position;
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                // hold the token's findings once it leaves the last cell
                if (tok_exit.valid) begin
                    found_next = tok_exit.found;
                    fidx_next  = tok_exit.fidx;
                    rval_next  = tok_exit.rval;
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (commit) begin
                    cell_op       = res_op;
                    length_next   = res_length;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_inserted, res_index, res_value, res_status};
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            length_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            length_reg   <= length_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        cmd_reg     <= cmd_next;
        value_reg   <= value_next;
        pos_reg     <= pos_next;
        found_reg   <= found_next;
        fidx_reg    <= fidx_next;
        rval_reg    <= rval_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign length   = length_reg;

endmodule

/* design/bounded_list_table_engine.sv */
// An accepted request launches the lookup token down the 16-cell chain; S_WALK captures
// its findings and S_FINISH commits the result once the output register is free.
// A request is taken only once the last one commits; the token moves one cell per cycle.
// The output register lets a new request in while the previous result waits.
// Reset: synchronous, active low aresetn; empties the list, entries keep stale data.
`timescale 1ns / 1ps

module bounded_list_table_engine
    import bl_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // command[2:0], value[34:3], position[38:35], 0
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status[2:0], value_out[34:3], index_out[38:35],
                                        // inserted[39]
);

    tok_t              tok_launch;
    tok_t              tok_chain [DEPTH];
    logic [DATA_W-1:0] entry_chain [DEPTH];
    cell_op_t          cell_op;
    logic [LEN_W-1:0]  length;

    bl_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .tok_launch (tok_launch),
        .tok_exit   (tok_chain[DEPTH-1]),
        .cell_op    (cell_op),
        .length     (length)
    );

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [DATA_W-1:0] lower;
        logic [DATA_W-1:0] upper;
        tok_t              tin;

        if (k == 0) begin : g_first
            assign lower = cell_op.wdata;
            assign tin   = tok_launch;
        end else begin : g_mid
            assign lower = entry_chain[k-1];
            assign tin   = tok_chain[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign upper = entry_chain[k];
        end else begin : g_inner
            assign upper = entry_chain[k+1];
        end

        bl_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cell_index  (LEN_W'(k)),
            .length      (length),
            .op          (cell_op),
            .lower_entry (lower),
            .upper_entry (upper),
            .tok_in      (tin),
            .entry       (entry_chain[k]),
            .tok_out     (tok_chain[k])
        );
    end

endmodule

/* design/bl_checker.sv */
// Port-level checker for the bounded list table engine, bound to the top level.
// Depends on bl_pkg and bounded_list_table_engine_assert.svh.
`timescale 1ns / 1ps
`include "bounded_list_table_engine_assert.svh"

module bl_checker
    import bl_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [IN_W-1:0]  s_tdata,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    logic [STAT_W-1:0] status_w;
    logic [DATA_W-1:0] value_w;
    logic [OIDX_W-1:0] index_w;
    logic              ins_w;

    assign status_w = m_tdata[STAT_W-1:0];
    assign value_w  = m_tdata[STAT_W+DATA_W-1:STAT_W];
    assign index_w  = m_tdata[STAT_W+DATA_W+OIDX_W-1:STAT_W+DATA_W];
    assign ins_w    = m_tdata[OUT_W-1];

    // a stalled result holds
    `BLTE_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    // a request is worked on alone: no second request right after one is taken
    `BLTE_ASSERT(a_one_at_time, aclk, aresetn, s_tvalid && s_tready |=> !s_tready)
    // append flag and returned value only come with a good status
    `BLTE_ASSERT(a_ins_ok, aclk, aresetn, m_tvalid && (ins_w || value_w != '0) |-> status_w == ST_OK)
    // failed commands report index zero
    `BLTE_ASSERT(a_fail_idx, aclk, aresetn, m_tvalid && status_w != ST_OK |-> index_w == '0)

endmodule

bind bounded_list_table_engine bl_checker u_bl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* sim/bounded_list_table_engine_tb.sv */
// Self-checking testbench for the bounded list table engine: queued requests
// drive the stream input, and an in-bench list predictor checks every result.
// Depends on bl_pkg and the bounded_list_table_engine RTL.
`timescale 1ns / 1ps

module bounded_list_table_engine_tb;
    import bl_pkg::*;

    localparam int RANDOM_ITEMS = 1450;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE       = 40;

    // Command codes the block does not define.
    localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    // Request word, first member in the top bits: pad, position, value, command.
    typedef struct packed {
        logic                pad;
        logic [POS_W-1:0]    position;
        logic [DATA_W-1:0]   value;
        logic [CMD_W-1:0]    command;
    } list_req_t;

    // Result word: inserted, index, value, status.
    typedef struct packed {
        logic                inserted;
        logic [OIDX_W-1:0]   index;
        logic [DATA_W-1:0]   value;
        status_t             status;
    } list_result_t;

    typedef struct {
        list_req_t   req;
        int unsigned phase;
        bit          hold;
    } queued_cmd_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    queued_cmd_t      cmd_q[$];
    list_result_t     answer_q[$];
    logic [DATA_W-1:0] plan_list[$];

    logic [DATA_W-1:0] list_mem[DEPTH];
    int               list_len = 0;
    int unsigned      cur_phase = 0;
    int               mismatches = 0;
    int               quiet_cycles = 0;

    bounded_list_table_engine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic bit roll_idle(input int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic int first_slot(input logic [DATA_W-1:0] key);
        int idx;
        idx = 0;
        while (idx < list_len && list_mem[idx] != key)
            idx++;
        return idx;
    endfunction

    // Apply one command to the predicted list and produce its answer.
    task automatic apply_list_cmd(input list_req_t req, output list_result_t res);
        int idx;
        int mid;
        res = '0;
        case (req.command)
            CMD_PUSH_FRONT: begin
                if (list_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (idx = list_len; idx > 0; idx--)
                        list_mem[idx] = list_mem[idx - 1];
                    list_mem[0] = req.value;
                    list_len++;
                end
            end
            CMD_PUSH_BACK: begin
                if (list_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    list_mem[list_len] = req.value;
                    res.index = OIDX_W'(list_len);
                    list_len++;
                end
            end
            CMD_SEARCH: begin
                idx = first_slot(req.value);
                if (idx < list_len)
                    res.index = OIDX_W'(idx);
                else
                    res.status = ST_NOT_FOUND;
            end
            CMD_READ: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else if (int'(req.position) >= list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    res.value = list_mem[req.position];
                    res.index = req.position;
                end
            end
            CMD_FIND_INSERT: begin
                idx = first_slot(req.value);
                if (idx < list_len) begin
                    res.index = OIDX_W'(idx);
                end else if (list_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    list_mem[list_len] = req.value;
                    res.index    = OIDX_W'(list_len);
                    res.inserted = 1'b1;
                    list_len++;
                end
            end
            CMD_REMOVE_MID: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else if (list_len % 2 == 0) begin
                    res.status = ST_EVEN;
                end else begin
                    mid       = list_len / 2;
                    res.value = list_mem[mid];
                    res.index = OIDX_W'(mid);
                    for (idx = mid; idx + 1 < list_len; idx++)
                        list_mem[idx] = list_mem[idx + 1];
                    list_len--;
                end
            end
            default: res.status = ST_RANGE;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        if (mismatches < 40)
            $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic bit plan_holds(input logic [DATA_W-1:0] key);
        foreach (plan_list[i])
            if (plan_list[i] == key)
                return 1'b1;
        return 1'b0;
    endfunction

    // Queue one request and track list contents so stimulus can steer the length.
    task automatic plan_item(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val,
                             input logic [POS_W-1:0] pos, input int unsigned ph,
                             input bit hold);
        queued_cmd_t item;
        int          n;
        item.req          = '0;
        item.req.command  = cmd;
        item.req.value    = val;
        item.req.position = pos;
        item.phase        = ph;
        item.hold         = hold;
        cmd_q.push_back(item);
        n = plan_list.size();
        case (cmd)
            CMD_PUSH_FRONT:  if (n < DEPTH) plan_list.push_front(val);
            CMD_PUSH_BACK:   if (n < DEPTH) plan_list.push_back(val);
            CMD_FIND_INSERT: if (n < DEPTH && !plan_holds(val)) plan_list.push_back(val);
            CMD_REMOVE_MID:  if (n % 2 == 1) plan_list.delete(n / 2);
            default: ;
        endcase
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            case ($urandom_range(0, 3))
                0: return 32'h7fff_ffff;
                1: return 32'h8000_0000;
                2: return 32'hffff_ffff;
                default: return 32'h0;
            endcase
        end
        // Small signed pool for duplicates and search hits.
        if (roll < 40)
            return DATA_W'($signed($urandom_range(0, 7)) - 4);
        return $urandom;
    endfunction

    // Request driver: hold a request until taken, honor drain points and idling.
    always @(posedge aclk) begin : feed_requests
        queued_cmd_t  nxt;
        list_result_t answer;
        bit           pause;
        int unsigned  pct;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_list_cmd(list_req_t'(s_tdata), answer);
                answer_q.push_back(answer);
            end
            if (!s_tvalid || s_tready) begin
                pause = (cmd_q.size() == 0);
                if (!pause) begin
                    nxt   = cmd_q[0];
                    pct   = (nxt.phase == 1) ? 60 : (nxt.phase == 3) ? 19 : 0;
                    pause = (nxt.hold && answer_q.size() != 0) || roll_idle(pct);
                end
                if (pause) begin
                    s_tvalid <= 1'b0;
                end else begin
                    nxt       = cmd_q.pop_front();
                    cur_phase = nxt.phase;
                    s_tvalid  <= 1'b1;
                    s_tdata   <= nxt.req;
                end
            end
        end
    end

    // Result monitor: compare each accepted result with the oldest prediction.
    always @(posedge aclk) begin : check_results
        list_result_t got;
        list_result_t want;
        int unsigned  pct;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = list_result_t'(m_tdata);
                if (answer_q.size() == 0) begin
                    report_mismatch("result with no request pending", m_tdata[DATA_W-1:0], '0);
                end else begin
                    want = answer_q.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", DATA_W'(got.status), DATA_W'(want.status));
                    if (got.value !== want.value)
                        report_mismatch("value_out", got.value, want.value);
                    if (got.index !== want.index)
                        report_mismatch("index_out", DATA_W'(got.index), DATA_W'(want.index));
                    if (got.inserted !== want.inserted)
                        report_mismatch("inserted", DATA_W'(got.inserted),
                                        DATA_W'(want.inserted));
                end
            end
            pct = (cur_phase == 2) ? 60 : (cur_phase == 3) ? 19 : 0;
            m_tready <= !roll_idle(pct);
        end
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] val;
        logic [POS_W-1:0]  pos;
        int unsigned       ph;
        int unsigned       roll;
        int                n;
        int                len;
        int                goal;
        bit                hold;

        // Directed: empty-list cases, single entry, extremes, even and odd removal.
        plan_item(CMD_READ,        32'h0,         4'd0,  0, 1'b0);
        plan_item(CMD_REMOVE_MID,  32'h0,         4'd0,  0, 1'b0);
        plan_item(CMD_SEARCH,      32'h0,         4'd0,  0, 1'b0);
        plan_item(CMD_PUSH_BACK,   32'h7fff_ffff, 4'd0,  0, 1'b0);
        plan_item(CMD_REMOVE_MID,  32'h0,         4'd0,  0, 1'b0);
        plan_item(CMD_FIND_INSERT, 32'h8000_0000, 4'd0,  0, 1'b0);
        plan_item(CMD_PUSH_FRONT,  32'hffff_ffff, 4'd0,  0, 1'b0);
        plan_item(CMD_PUSH_FRONT,  32'h0,         4'd0,  0, 1'b0);
        plan_item(CMD_PUSH_BACK,   32'h5555_5555, 4'd15, 0, 1'b0);
        plan_item(CMD_REMOVE_MID,  32'h0,         4'd0,  0, 1'b1);
        plan_item(CMD_READ,        32'h0,         4'd15, 0, 1'b0);
        plan_item(CMD_READ,        32'h0,         4'd3,  0, 1'b0);
        plan_item(CMD_READ,        32'h0,         4'd4,  0, 1'b0);
        plan_item(CMD_SEARCH,      32'h8000_0000, 4'd0,  0, 1'b0);
        plan_item(CMD_SEARCH,      32'haaaa_aaaa, 4'd0,  0, 1'b0);
        plan_item(CMD_FIND_INSERT, 32'hffff_ffff, 4'd0,  0, 1'b0);
        plan_item(CMD_FIND_INSERT, 32'haaaa_aaaa, 4'd0,  0, 1'b0);
        plan_item(CMD_REMOVE_MID,  32'h0,         4'd0,  0, 1'b0);
        plan_item(CMD_RSVD_6,      32'hffff_ffff, 4'd15, 0, 1'b0);
        plan_item(CMD_RSVD_7,      32'h0,         4'd0,  0, 1'b0);

        // Random: length may only shrink from odd, so ramp a target length from
        // empty to full across the run and oscillate around it.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            ph   = n * 4 / RANDOM_ITEMS;
            hold = (n % (RANDOM_ITEMS / 4) == 0) || ($urandom_range(0, 99) == 0);
            goal = n * 18 / RANDOM_ITEMS;
            if (goal > DEPTH)
                goal = DEPTH;
            len  = plan_list.size();
            val  = pick_value();
            if (len > 0 && $urandom_range(0, 4) != 0)
                pos = POS_W'($urandom_range(0, len - 1));
            else
                pos = POS_W'($urandom_range(0, 15));
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                cmd = $urandom_range(0, 1) ? CMD_RSVD_6 : CMD_RSVD_7;
            end else if (roll < 45) begin
                case ($urandom_range(0, 2))
                    0: begin
                        cmd = CMD_SEARCH;
                        if (len > 0 && $urandom_range(0, 1))
                            val = plan_list[$urandom_range(0, len - 1)];
                    end
                    1: cmd = CMD_READ;
                    default: begin
                        cmd = CMD_FIND_INSERT;
                        if (len > 0)
                            val = plan_list[$urandom_range(0, len - 1)];
                    end
                endcase
            end else if (roll < 65 || (len >= goal && len % 2 == 1 && goal < DEPTH)) begin
                cmd = CMD_REMOVE_MID;
            end else begin
                case ($urandom_range(0, 2))
                    0: cmd = CMD_PUSH_FRONT;
                    1: cmd = CMD_PUSH_BACK;
                    default: cmd = CMD_FIND_INSERT;
                endcase
            end
            plan_item(cmd, val, pos, ph, hold);
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (cmd_q.size() != 0 || s_tvalid || answer_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/bl_pkg.sv
design/bl_cell.sv
design/bl_ctrl.sv
design/bounded_list_table_engine.sv
design/bl_checker.sv
sim/bounded_list_table_engine_tb.sv
